// File: hw/rtl/mbtcp_pkg.sv
// Package for the Modbus TCP holding register server.
// Sizes, function codes, response constants and the register file request bundle.
// No dependencies.
package mbtcp_pkg;

  localparam int REG_COUNT         = 256;
  localparam int MAX_READ_QUANTITY = 16;
  localparam int HDR_LEN           = 12;

  localparam int REG_AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int QTY_W  = $clog2(MAX_READ_QUANTITY + 1);
  localparam int POS_W  = $clog2(HDR_LEN + 1);

  // Request byte offsets
  localparam int HDR_UNIT   = 6;
  localparam int HDR_FC     = 7;
  localparam int HDR_ADDR_H = 8;
  localparam int HDR_ADDR_L = 9;
  localparam int HDR_QTY_H  = 10;
  localparam int HDR_QTY_L  = 11;

  // Read response header: four id bytes, length high, length low, unit, fc, byte count
  localparam int RSP_LEN_H = 4;
  localparam int RSP_LEN_L = 5;
  localparam int RSP_BCNT  = 8;

  localparam logic [7:0] FC_READ  = 8'h03;
  localparam logic [7:0] FC_WRITE = 8'h06;
  localparam logic [7:0] LEN_HIGH = 8'h00;
  localparam logic [7:0] ERR_BYTE = 8'h00;
  localparam logic [15:0] LEN_BASE = 16'd3;

  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] waddr;
    logic [15:0]       wdata;
    logic [REG_AW-1:0] raddr;
  } rf_req_t;

endpackage

// File: hw/rtl/mbtcp_if.sv
// Valid/ready channel interfaces for request bytes and response bytes.
// Depends on nothing; used by the top level.
interface mbtcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_start;

  modport source (output valid, output frame_byte, output frame_start, input ready);
  modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

interface mbtcp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       error_flag;

  modport source (output valid, output out_byte, output last_byte, output error_flag,
                  input ready);
  modport sink   (input valid, input out_byte, input last_byte, input error_flag,
                  output ready);
endinterface

// File: hw/rtl/mbtcp_regfile.sv
// Holding register file: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on mbtcp_pkg.
module mbtcp_regfile (
  input  logic             clk,
  input  logic             rst_n,
  input  mbtcp_pkg::rf_req_t req,
  output logic [15:0]      rdata
);
  import mbtcp_pkg::*;

  logic [15:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [15:0]          rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= vld_r[req.raddr] ? mem[req.raddr] : 16'd0;
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/modbus_tcp_register_server.sv
// Modbus TCP holding register server, top level.
// Collects 12-byte requests, serves read (fc 3) and write single (fc 6) responses.
// Depends on mbtcp_pkg, mbtcp_if.sv and mbtcp_regfile.
//
//  channel | dir | beat payload                       | handshake
//  --------+-----+------------------------------------+------------
//  in_ch   | in  | frame_byte[7:0], frame_start        | valid/ready
//  out_ch  | out | out_byte[7:0], last_byte, error_flag| valid/ready
//
// All 12 request bytes are taken one per cycle while in_ch.valid is high. After
// byte 12 the block passes a decode state, then sends the response: 1 beat for an
// error, 12 for a write echo, 9 + 2*quantity beats for a read (fetch, high byte,
// low byte per register, paced by the single register file read port). in_ch.ready
// is low until the last beat has been loaded into the output register. out_ch.ready
// low stalls the sequencer. Synchronous active-low reset clears the register file.
module modbus_tcp_register_server (
  input  logic              clk,
  input  logic              rst_n,
  mbtcp_in_if.sink          in_ch,
  mbtcp_out_if.source       out_ch
);
  import mbtcp_pkg::*;

  typedef enum logic [5:0] {
    S_RECV   = 6'b000001,
    S_DECODE = 6'b000010,
    S_HEAD   = 6'b000100,
    S_FETCH  = 6'b001000,
    S_HIGH   = 6'b010000,
    S_LOW    = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    M_READ  = 2'd0,
    M_WRITE = 2'd1,
    M_ERR   = 2'd2
  } mode_t;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [3:0]        k_r, k_nxt;        // header beat counter
  logic [REG_AW-1:0] addr_r, addr_nxt;  // register being read
  logic [QTY_W-1:0]  qty_r, qty_nxt;
  logic [QTY_W-1:0]  left_r, left_nxt;  // registers still to send

  logic [7:0]        hdr_r [HDR_LEN];
  logic [3:0]        hdr_idx;
  logic              in_acc;

  // output register
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              out_err_r;
  logic              slot_free;
  logic              emit;
  logic [7:0]        emit_byte;
  logic              emit_last;
  logic              emit_err;

  // shared adder: range check, length byte, address step
  logic [15:0]       opa, opb;
  logic [16:0]       sum;

  logic [15:0]       req_addr, req_qty;
  logic [QTY_W:0]    nbytes;
  rf_req_t           rf_req;
  logic [15:0]       rf_rdata;

  assign req_addr = {hdr_r[HDR_ADDR_H], hdr_r[HDR_ADDR_L]};
  assign req_qty  = {hdr_r[HDR_QTY_H], hdr_r[HDR_QTY_L]};
  assign nbytes   = {qty_r, 1'b0};
  assign sum      = {1'b0, opa} + {1'b0, opb};

  assign in_ch.ready = (state_r == S_RECV);
  assign in_acc      = in_ch.valid && in_ch.ready;
  // frame_start resyncs to byte 0
  assign hdr_idx     = (in_ch.frame_start || (pos_r >= POS_W'(HDR_LEN))) ? 4'd0
                       : 4'(pos_r);
  assign slot_free   = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    addr_nxt  = addr_r;
    qty_nxt   = qty_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    emit_byte = 8'd0;
    emit_last = 1'b0;
    emit_err  = 1'b0;
    opa       = req_addr;
    opb       = req_qty;
    rf_req.we    = 1'b0;
    rf_req.waddr = req_addr[REG_AW-1:0];
    rf_req.wdata = req_qty;
    rf_req.raddr = addr_r;

    unique case (state_r)
      S_RECV: begin
        if (in_acc) begin
          if (hdr_idx == 4'(HDR_LEN - 1)) begin
            pos_nxt   = '0;
            state_nxt = S_DECODE;
          end else begin
            pos_nxt = POS_W'(hdr_idx) + POS_W'(1);
          end
        end
      end

      S_DECODE: begin
        // sum = start + quantity here
        k_nxt     = 4'd0;
        addr_nxt  = req_addr[REG_AW-1:0];
        qty_nxt   = req_qty[QTY_W-1:0];
        left_nxt  = req_qty[QTY_W-1:0];
        state_nxt = S_HEAD;
        if (hdr_r[HDR_FC] == FC_READ) begin
          if (req_qty == 16'd0 || req_qty > 16'(MAX_READ_QUANTITY) ||
              sum > 17'(REG_COUNT)) begin
            mode_nxt = M_ERR;
          end else begin
            mode_nxt = M_READ;
          end
        end else if (hdr_r[HDR_FC] == FC_WRITE) begin
          if ({1'b0, req_addr} >= 17'(REG_COUNT)) begin
            mode_nxt = M_ERR;
          end else begin
            mode_nxt  = M_WRITE;
            rf_req.we = 1'b1;
          end
        end else begin
          state_nxt = S_RECV;  // unsupported code: drop silently
        end
      end

      S_HEAD: begin
        opa = LEN_BASE;
        opb = 16'(nbytes);
        if (mode_r == M_ERR) begin
          emit_byte = ERR_BYTE;
          emit_last = 1'b1;
          emit_err  = 1'b1;
        end else if (mode_r == M_WRITE) begin
          emit_byte = hdr_r[k_r];
          emit_last = (k_r == 4'(HDR_LEN - 1));
        end else begin
          if (k_r == 4'(RSP_LEN_H)) begin
            emit_byte = LEN_HIGH;
          end else if (k_r == 4'(RSP_LEN_L)) begin
            emit_byte = sum[7:0];
          end else if (k_r == 4'(RSP_BCNT)) begin
            emit_byte = 8'(nbytes);
          end else begin
            emit_byte = hdr_r[k_r];
          end
        end
        if (slot_free) begin
          emit  = 1'b1;
          k_nxt = k_r + 4'd1;
          if (mode_r == M_ERR || emit_last) begin
            state_nxt = S_RECV;
          end else if (mode_r == M_READ && k_r == 4'(RSP_BCNT)) begin
            state_nxt = S_FETCH;
          end
        end
      end

      S_FETCH: begin
        state_nxt = S_HIGH;  // read data lands in rf_rdata
      end

      S_HIGH: begin
        emit_byte = rf_rdata[15:8];
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = S_LOW;
        end
      end

      S_LOW: begin
        opa       = 16'(addr_r);
        opb       = 16'd1;
        emit_byte = rf_rdata[7:0];
        emit_last = (left_r == QTY_W'(1));
        if (slot_free) begin
          emit      = 1'b1;
          addr_nxt  = sum[REG_AW-1:0];
          left_nxt  = left_r - QTY_W'(1);
          state_nxt = emit_last ? S_RECV : S_FETCH;
        end
      end

      default: begin
        state_nxt = S_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RECV;
      mode_r      <= M_READ;
      pos_r       <= '0;
      k_r         <= 4'd0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      k_r     <= k_nxt;
      left_r  <= left_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    qty_r  <= qty_nxt;
    if (in_acc) begin
      hdr_r[hdr_idx] <= in_ch.frame_byte;
    end
    if (emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
      out_err_r  <= emit_err;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.last_byte  = out_last_r;
  assign out_ch.error_flag = out_err_r;

  mbtcp_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rf_req),
    .rdata (rf_rdata)
  );

endmodule
